/* rtl/ptb_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Timer bank package
// Shared widths, item codes and the stored entry layout of the timer bank.
// ----------------------------------------------------------------------------
package ptb_pkg;

	localparam int DEFAULT_NUM_TIMERS = 10;

	localparam int MODE_W  = 3;
	localparam int INDEX_W = 4;
	localparam int VALUE_W = 16;

	typedef enum logic [MODE_W-1:0] {
		MODE_TICK        = 3'd0,
		MODE_SET         = 3'd1,
		MODE_SET_SHIFT   = 3'd2,
		MODE_READ_EXPIRY = 3'd3,
		MODE_READ_WINDOW = 3'd4
	} ptb_mode_t;

	// One timer as held in the entry memory
	typedef struct packed {
		logic [VALUE_W-1:0] preset;
		logic [VALUE_W-1:0] shift;
		logic [VALUE_W-1:0] count;
	} ptb_entry_t;

endpackage
`default_nettype wire

/* rtl/ptb_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Timer bank channels
// Command channel (items in) and response channel (read flag out).
// ----------------------------------------------------------------------------
interface ptb_cmd_if
	import ptb_pkg::*;
();
	logic               valid;
	logic               ready;
	logic [MODE_W-1:0]  mode;
	logic [INDEX_W-1:0] timer_index;
	logic [VALUE_W-1:0] preset_value;
	logic [VALUE_W-1:0] shift_value;

	modport source (output valid, mode, timer_index, preset_value, shift_value, input ready);
	modport sink   (input valid, mode, timer_index, preset_value, shift_value, output ready);
endinterface

interface ptb_rsp_if;
	logic valid;
	logic ready;
	logic read_flag;

	modport source (output valid, read_flag, input ready);
	modport sink   (input valid, read_flag, output ready);
endinterface
`default_nettype wire

/* rtl/periodic_timer_bank.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Periodic timer bank
// Bank of auto-reload down-counting timers with sticky expiry and window flags.
// ----------------------------------------------------------------------------
// Usage:
//   cmd carries one word per item: a tick, a preset write, a preset and shift
//   write, a read-and-clear of the expiry flag, or a read of the window flag.
//   rsp returns exactly one word per command, read_flag, which is 0 for ticks,
//   writes, unused modes and indices at or above NUM_TIMERS.
//   Response: the response word is registered at the accepting edge and shows
//   on rsp in the next cycle, for every mode.
//   Throughput: a write or read can be taken every clock while rsp does not
//   stall. A tick walks the entry memory one timer a cycle (read, then modify
//   and write back in the next cycle), so cmd stays low after a tick through
//   the sweep and drain states. The single memory port pair sets this.
//   Reset: arst_n clears all flags and the per-entry valid bits; an entry not
//   yet written reads as all zero, so no clearing pass is needed.
//   Stall: a response waiting on rsp holds; a new command is still taken in
//   the cycle the waiting word is consumed, and otherwise waits.
// ----------------------------------------------------------------------------
module periodic_timer_bank
	import ptb_pkg::*;
#(
	parameter int NUM_TIMERS = DEFAULT_NUM_TIMERS
) (
	input  wire         clk,
	input  wire         arst_n,
	ptb_cmd_if.sink     cmd,
	ptb_rsp_if.source   rsp
);

	localparam int ADDR_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SWEEP,
		ST_DRAIN
	} state_t;

	state_t state_q;

	// Entry memory: preset, shift and count of each timer
	ptb_entry_t mem [NUM_TIMERS];

	logic [NUM_TIMERS-1:0] ent_vld_q;   // entry written since reset
	logic [NUM_TIMERS-1:0] expiry_q;
	logic [NUM_TIMERS-1:0] window_q;

	logic              rsp_valid_q;
	logic              rsp_flag_q;

	// Sweep read pointer and the stage that holds the read data
	logic [ADDR_W-1:0] rd_idx_q;
	logic              sweep_s1;
	logic [ADDR_W-1:0] idx_s1;
	logic              ent_vld_s1;
	ptb_entry_t        rd_data_s1;

	// Command decode
	logic              accept;
	ptb_mode_t         mode;
	logic              idx_ok;
	logic [ADDR_W-1:0] cmd_addr;
	logic              is_set;
	logic              read_flag;

	// Memory write port
	logic              mem_we;
	logic              mem_we_shift;
	logic [ADDR_W-1:0] mem_waddr;
	ptb_entry_t        mem_wdata;

	// Tick update of the entry in stage one
	ptb_entry_t        cur;
	ptb_entry_t        nxt;
	logic              set_expiry;
	logic              set_window;
	logic              clr_window;

	assign cmd.ready = (state_q == ST_IDLE) && (!rsp_valid_q || rsp.ready);
	assign accept    = cmd.valid && cmd.ready;
	assign mode      = ptb_mode_t'(cmd.mode);
	assign idx_ok    = (32'(cmd.timer_index) < NUM_TIMERS);
	assign cmd_addr  = cmd.timer_index[ADDR_W-1:0];
	assign is_set    = idx_ok && ((mode == MODE_SET) || (mode == MODE_SET_SHIFT));

	assign rsp.valid     = rsp_valid_q;
	assign rsp.read_flag = rsp_flag_q;

	always_comb begin
		read_flag = 1'b0;
		case (mode)
			MODE_READ_EXPIRY: read_flag = idx_ok && expiry_q[cmd_addr];
			MODE_READ_WINDOW: read_flag = idx_ok && window_q[cmd_addr];
			default:          read_flag = 1'b0;
		endcase
	end

	// Unwritten entries read as zero
	assign cur = ent_vld_s1 ? rd_data_s1 : '0;

	always_comb begin
		nxt        = cur;
		set_expiry = 1'b0;
		set_window = 1'b0;
		clr_window = 1'b0;
		if (cur.count != '0) begin
			set_expiry = (cur.count == VALUE_W'(1));
			set_window = (cur.count == cur.shift);
			nxt.count  = cur.count - VALUE_W'(1);
		end else begin
			clr_window = 1'b1;
			nxt.count  = cur.preset;
		end
	end

	// Write port: sweep write-back, or a set item from the command side.
	// The two never meet: cmd is held off for the whole sweep.
	always_comb begin
		if (sweep_s1) begin
			mem_we       = 1'b1;
			mem_we_shift = 1'b1;
			mem_waddr    = idx_s1;
			mem_wdata    = nxt;
		end else begin
			mem_we       = accept && is_set;
			// a preset-only write to a fresh entry must still zero its shift
			mem_we_shift = (mode == MODE_SET_SHIFT) || !ent_vld_q[cmd_addr];
			mem_waddr    = cmd_addr;
			mem_wdata.preset = cmd.preset_value;
			mem_wdata.count  = cmd.preset_value;
			mem_wdata.shift  = (mode == MODE_SET_SHIFT) ? cmd.shift_value : '0;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr].preset <= mem_wdata.preset;
			mem[mem_waddr].count  <= mem_wdata.count;
			if (mem_we_shift) begin
				mem[mem_waddr].shift <= mem_wdata.shift;
			end
		end
		rd_data_s1 <= mem[rd_idx_q];
		idx_s1     <= rd_idx_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
			rsp_flag_q  <= 1'b0;
			rd_idx_q    <= '0;
			sweep_s1    <= 1'b0;
			ent_vld_s1  <= 1'b0;
			ent_vld_q   <= '0;
			expiry_q    <= '0;
			window_q    <= '0;
		end else begin
			// drop the response word once taken
			if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end

			sweep_s1   <= 1'b0;
			ent_vld_s1 <= ent_vld_q[rd_idx_q];

			case (state_q)
				ST_IDLE: begin
					rd_idx_q <= '0;
					if (accept) begin
						rsp_valid_q <= 1'b1;
						rsp_flag_q  <= read_flag;
						if (mode == MODE_TICK) begin
							state_q <= ST_SWEEP;
						end
						if (is_set) begin
							ent_vld_q[cmd_addr] <= 1'b1;
						end
						if (mode == MODE_READ_EXPIRY && idx_ok) begin
							expiry_q[cmd_addr] <= 1'b0;
						end
					end
				end
				ST_SWEEP: begin
					// issue one read a cycle; the data lands in stage one
					sweep_s1 <= 1'b1;
					if (rd_idx_q == ADDR_W'(NUM_TIMERS - 1)) begin
						state_q <= ST_DRAIN;
					end else begin
						rd_idx_q <= rd_idx_q + ADDR_W'(1);
					end
				end
				ST_DRAIN: begin
					// last write-back happens at this edge
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase

			// advance the timer in stage one
			if (sweep_s1) begin
				ent_vld_q[idx_s1] <= 1'b1;
				if (set_expiry) begin
					expiry_q[idx_s1] <= 1'b1;
				end
				if (set_window) begin
					window_q[idx_s1] <= 1'b1;
				end else if (clr_window) begin
					window_q[idx_s1] <= 1'b0;
				end
			end
		end
	end

endmodule
`default_nettype wire

/* rtl/ptb_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Timer bank port checker
// Watches the command and response channels of the timer bank.
// ----------------------------------------------------------------------------
module ptb_checker
	import ptb_pkg::*;
(
	input wire               clk,
	input wire               arst_n,
	input wire               cmd_valid,
	input wire               cmd_ready,
	input wire [MODE_W-1:0]  cmd_mode,
	input wire               rsp_valid,
	input wire               rsp_ready,
	input wire               rsp_read_flag
);

	logic cmd_acc;
	assign cmd_acc = cmd_valid && cmd_ready;

	// A waiting response word holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_flag))
		else $error("response word changed while stalled");

	// Every accepted command gives a response word in the next cycle
	a_rsp_follows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_acc |=> rsp_valid)
		else $error("no response after accepted command");

	// A tick occupies the bank: no command taken right after it
	a_tick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_acc && (cmd_mode == MODE_TICK) |=> !cmd_ready)
		else $error("command taken during tick sweep");

	// Only read items can answer a one
	a_flag_zero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_acc && (cmd_mode != MODE_READ_EXPIRY) && (cmd_mode != MODE_READ_WINDOW)
		|=> !rsp_read_flag)
		else $error("nonzero flag for non-read command");

endmodule

bind periodic_timer_bank ptb_checker u_ptb_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.cmd_valid     (cmd.valid),
	.cmd_ready     (cmd.ready),
	.cmd_mode      (cmd.mode),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.rsp_read_flag (rsp.read_flag)
);
`default_nettype wire

/* sim/tb_periodic_timer_bank.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Periodic timer bank testbench
// Drives ticks, preset writes and flag reads into the timer bank, keeps a
// shadow of every timer's count and flags, and checks each read_flag word in
// order against the shadow. Both channel sides idle at random in two of the
// three random phases, and the response side stalls for a long stretch at least once.
// ----------------------------------------------------------------------------
module tb_periodic_timer_bank;
	import ptb_pkg::*;

	localparam int NUM_TIMERS = DEFAULT_NUM_TIMERS;
	// Codes the package leaves unnamed; the bank must ignore them
	localparam logic [MODE_W-1:0] MODE_SPARE_FIRST = 3'd5;
	localparam logic [MODE_W-1:0] MODE_SPARE_LAST  = 3'd7;
	localparam logic [INDEX_W-1:0] INDEX_MAX = {INDEX_W{1'b1}};
	localparam logic [VALUE_W-1:0] VALUE_MAX = {VALUE_W{1'b1}};
	localparam int PHASE_ITEMS   = 285;
	localparam int LONG_HOLD     = 250;
	localparam int DRAIN_CYCLES  = NUM_TIMERS + 8;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int MAX_MSG_LINES = 40;

	// Shadow of the whole timer bank and the read_flag words still owed
	class timer_bank_scoreboard;
		bit [VALUE_W-1:0] reload_val[NUM_TIMERS];
		bit [VALUE_W-1:0] count_val[NUM_TIMERS];
		bit [VALUE_W-1:0] window_at[NUM_TIMERS];
		bit               expired[NUM_TIMERS];
		bit               in_window[NUM_TIMERS];
		bit               owed_flags[$];

		// Apply one accepted command word and queue the flag it must answer
		function void note_command(logic [MODE_W-1:0] m, logic [INDEX_W-1:0] idx,
				logic [VALUE_W-1:0] pv, logic [VALUE_W-1:0] sv);
			bit hit;
			bit flag;
			hit  = idx < NUM_TIMERS;
			flag = 1'b0;
			case (m)
				MODE_TICK: begin
					for (int t = 0; t < NUM_TIMERS; t++) begin
						if (count_val[t] != 0) begin
							if (count_val[t] == 1)
								expired[t] = 1'b1;
							if (count_val[t] == window_at[t])
								in_window[t] = 1'b1;
							count_val[t] = count_val[t] - 1'b1;
						end else begin
							in_window[t] = 1'b0;
							count_val[t] = reload_val[t];
						end
					end
				end
				MODE_SET: begin
					if (hit) begin
						reload_val[idx] = pv;
						count_val[idx]  = pv;
					end
				end
				MODE_SET_SHIFT: begin
					if (hit) begin
						reload_val[idx] = pv;
						window_at[idx]  = sv;
						count_val[idx]  = pv;
					end
				end
				MODE_READ_EXPIRY: begin
					if (hit && expired[idx]) begin
						expired[idx] = 1'b0;
						flag = 1'b1;
					end
				end
				MODE_READ_WINDOW: begin
					if (hit)
						flag = in_window[idx];
				end
				default: ;
			endcase
			owed_flags.push_back(flag);
		endfunction

		// Empty string when the word matches the oldest owed flag
		function string check_flag(logic got);
			bit want;
			if (owed_flags.size() == 0)
				return $sformatf("read_flag %b with no command outstanding", got);
			want = owed_flags.pop_front();
			if (got !== want)
				return $sformatf("read_flag %b, expected %b", got, want);
			return "";
		endfunction

		function int pending();
			return owed_flags.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;

	ptb_cmd_if cmd ();
	ptb_rsp_if rsp ();

	periodic_timer_bank #(
		.NUM_TIMERS(NUM_TIMERS)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd),
		.rsp   (rsp)
	);

	timer_bank_scoreboard sb;
	int    mismatches = 0;
	int    cycles = 0;
	int    send_idle_pct;
	int    rcv_idle_pct = 0;
	int    hold_req = 0;
	int    hold_seen = 0;
	int    hold_left = 0;
	string check_msg;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Print a bounded number of lines but count every mismatch
	task automatic report_mismatch(input string msg);
		if (mismatches < MAX_MSG_LINES)
			$display("%0t ns: mismatch: %s", $time, msg);
		mismatches++;
	endtask

	// Hard stop in case the bank stops handshaking
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAIL periodic_timer_bank");
			$finish;
		end
	end

	// Response side: check every word taken, then pick ready for the next edge.
	// A hold request starts a long stretch of ready low, counted here, so the
	// response register fills and the bank has to stall its command side.
	always @(posedge clk) begin
		if (arst_n && rsp.valid && rsp.ready) begin
			check_msg = sb.check_flag(rsp.read_flag);
			if (check_msg != "")
				report_mismatch(check_msg);
		end
		if (!arst_n) begin
			rsp.ready <= 1'b0;
		end else if (hold_req != hold_seen) begin
			hold_seen <= hold_req;
			hold_left <= LONG_HOLD;
			rsp.ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			rsp.ready <= 1'b0;
		end else begin
			rsp.ready <= ($urandom_range(99) >= rcv_idle_pct);
		end
	end

	// Offer one command word, idling first by the sender's rate, and hold it
	// until the bank takes it. Returns just after the accepting edge, so the
	// next call may either drop valid or present the next word in that step.
	task automatic send_word(input logic [MODE_W-1:0] m, input logic [INDEX_W-1:0] idx,
			input logic [VALUE_W-1:0] pv, input logic [VALUE_W-1:0] sv);
		while ($urandom_range(99) < send_idle_pct) begin
			cmd.valid <= 1'b0;
			@(posedge clk);
		end
		cmd.valid        <= 1'b1;
		cmd.mode         <= m;
		cmd.timer_index  <= idx;
		cmd.preset_value <= pv;
		cmd.shift_value  <= sv;
		do
			@(posedge clk);
		while (!cmd.ready);
		sb.note_command(m, idx, pv, sv);
	endtask

	// Mostly live timers, now and then an index past the end of the bank
	function automatic logic [INDEX_W-1:0] pick_index();
		if ($urandom_range(9) == 0)
			return INDEX_W'($urandom_range(NUM_TIMERS, INDEX_MAX));
		return INDEX_W'($urandom_range(NUM_TIMERS - 1));
	endfunction

	// One random word. Short periods dominate so timers expire and open
	// windows often; ticks carry junk in the unused fields.
	task automatic random_word();
		int                 pick;
		logic [VALUE_W-1:0] pv;
		logic [VALUE_W-1:0] sv;
		pick = $urandom_range(99);
		pv   = VALUE_W'($urandom());
		sv   = VALUE_W'($urandom());
		if (pick < 40) begin
			send_word(MODE_TICK, INDEX_W'($urandom()), pv, sv);
		end else if (pick < 55) begin
			if ($urandom_range(9) != 0)
				pv = VALUE_W'($urandom_range(0, 12));
			send_word(MODE_SET, pick_index(), pv, sv);
		end else if (pick < 68) begin
			pv = VALUE_W'($urandom_range(1, 12));
			sv = VALUE_W'($urandom_range(0, pv + 1));
			send_word(MODE_SET_SHIFT, pick_index(), pv, sv);
		end else if (pick < 80) begin
			send_word(MODE_READ_EXPIRY, pick_index(), pv, sv);
		end else if (pick < 92) begin
			send_word(MODE_READ_WINDOW, pick_index(), pv, sv);
		end else begin
			// Noise: any code, any index, full-width values
			send_word(MODE_W'($urandom()), INDEX_W'($urandom()), pv, sv);
		end
	endtask

	initial begin
		sb            = new();
		send_idle_pct = 0;
		arst_n           <= 1'b0;
		cmd.valid        <= 1'b0;
		cmd.mode         <= MODE_TICK;
		cmd.timer_index  <= '0;
		cmd.preset_value <= '0;
		cmd.shift_value  <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset state, extremes, zero preset and zero shift,
		// expiry and window on short periods, read-clear, bad index, spare codes
		send_word(MODE_READ_EXPIRY, 0, 0, 0);
		send_word(MODE_READ_WINDOW, 0, 0, 0);
		send_word(MODE_SET_SHIFT, 0, 3, 2);
		send_word(MODE_SET, 1, 1, VALUE_MAX);
		send_word(MODE_SET_SHIFT, NUM_TIMERS - 1, VALUE_MAX, VALUE_MAX);
		send_word(MODE_SET_SHIFT, 2, 0, 0);
		send_word(MODE_SET_SHIFT, 3, 4, 0);
		repeat (4)
			send_word(MODE_TICK, INDEX_MAX, VALUE_MAX, VALUE_MAX);
		send_word(MODE_READ_WINDOW, 0, 0, 0);
		send_word(MODE_READ_WINDOW, 3, 0, 0);
		send_word(MODE_READ_EXPIRY, 0, 0, 0);
		send_word(MODE_READ_EXPIRY, 0, 0, 0);
		send_word(MODE_READ_EXPIRY, 1, 0, 0);
		send_word(MODE_READ_EXPIRY, 2, 0, 0);
		send_word(MODE_SET, NUM_TIMERS, 5, 0);
		send_word(MODE_SET_SHIFT, INDEX_MAX, 2, 1);
		send_word(MODE_READ_EXPIRY, INDEX_MAX, 0, 0);
		send_word(MODE_READ_WINDOW, NUM_TIMERS, 0, 0);
		for (int m = MODE_SPARE_FIRST; m <= MODE_SPARE_LAST; m++)
			send_word(MODE_W'(m), 0, VALUE_MAX, VALUE_MAX);
		send_word(MODE_TICK, 0, 0, 0);

		// Random, sender idling lightly and receiver heavily
		send_idle_pct = 24;
		rcv_idle_pct  <= 77;
		repeat (PHASE_ITEMS)
			random_word();

		// Swap the idle rates
		send_idle_pct = 77;
		rcv_idle_pct  <= 24;
		repeat (PHASE_ITEMS)
			random_word();

		// No idling; start a long response hold-off and keep offering words
		send_idle_pct = 0;
		rcv_idle_pct  <= 0;
		hold_req      <= hold_req + 1;
		repeat (PHASE_ITEMS)
			random_word();
		cmd.valid <= 1'b0;

		// Drain, then give the bank time for any stray word
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && sb.pending() == 0) begin
			$display("PASS periodic_timer_bank");
		end else begin
			$display("FAIL periodic_timer_bank");
		end
		$finish;
	end

endmodule
